// ----- hdl/assert_macros.svh -----
// Assertion macros used by the RTL of the 3x3 RGB convolution block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/c3rgb_pkg.sv -----
// Types and constants of the 3x3 RGB convolution block.
`default_nettype none

package c3rgb_pkg;

   // Field widths
   localparam int CHAN_W       = 8;
   localparam int PIXEL_W      = 3 * CHAN_W;
   localparam int COEF_W       = 16;
   localparam int COEF_ROW_W   = 3 * COEF_W;
   localparam int IMG_WIDTH_W  = 11;
   localparam int IMG_HEIGHT_W = 16;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = COEF_ROW_W;

   // Kernel arithmetic: Q4.12 taps, 9-bit signed pixel times 16-bit tap
   localparam int COEF_FRAC_BITS = 12;
   localparam int PROD_W         = COEF_W + CHAN_W + 1;
   localparam int SUM_W          = PROD_W + 4;

   // Register reset values
   localparam logic [COEF_ROW_W-1:0]   COEF_ROW0_RST    = 48'h0000_0000_0000;
   localparam logic [COEF_ROW_W-1:0]   COEF_ROW1_RST    = 48'h0000_1000_0000;
   localparam logic [COEF_ROW_W-1:0]   COEF_ROW2_RST    = 48'h0000_0000_0000;
   localparam logic [IMG_WIDTH_W-1:0]  IMG_WIDTH_RST    = 11'd640;
   localparam logic [IMG_HEIGHT_W-1:0] IMG_HEIGHT_RST   = 16'd480;

   typedef logic [PIXEL_W-1:0] pixel_type;

   // Item kinds on the request channel
   typedef enum logic [0:0] {
      FUNC_PIXEL = 1'b0,
      FUNC_DRAIN = 1'b1
   } func_type;

   // Register map
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_COEF_ROW0    = 3'd0,
      CSR_COEF_ROW1    = 3'd1,
      CSR_COEF_ROW2    = 3'd2,
      CSR_IMAGE_WIDTH  = 3'd3,
      CSR_IMAGE_HEIGHT = 3'd4
   } csr_index_type;

endpackage

`default_nettype wire

// ----- hdl/c3rgb_req_if.sv -----
// Request channel: one pixel or drain item per transfer.
`default_nettype none

interface c3rgb_req_if;
   logic                                  valid;
   logic                                  ready;
   c3rgb_pkg::func_type                   func;
   logic [c3rgb_pkg::CHAN_W-1:0]          in_red;
   logic [c3rgb_pkg::CHAN_W-1:0]          in_green;
   logic [c3rgb_pkg::CHAN_W-1:0]          in_blue;

   modport source (output valid, func, in_red, in_green, in_blue, input ready);
   modport sink   (input valid, func, in_red, in_green, in_blue, output ready);
endinterface

`default_nettype wire

// ----- hdl/c3rgb_rsp_if.sv -----
// Response channel: one output pixel per transfer.
`default_nettype none

interface c3rgb_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [c3rgb_pkg::CHAN_W-1:0]          out_red;
   logic [c3rgb_pkg::CHAN_W-1:0]          out_green;
   logic [c3rgb_pkg::CHAN_W-1:0]          out_blue;
   logic                                  frame_last;

   modport source (output valid, out_red, out_green, out_blue, frame_last, input ready);
   modport sink   (input valid, out_red, out_green, out_blue, frame_last, output ready);
endinterface

`default_nettype wire

// ----- hdl/c3rgb_csr_if.sv -----
// Register write channel: index and data per transfer.
`default_nettype none

interface c3rgb_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [c3rgb_pkg::CSR_INDEX_W-1:0]     index;
   logic [c3rgb_pkg::CSR_DATA_W-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hdl/convolution_3x3_rgb_top.sv -----
// Top level of the 3x3 RGB convolution block: line stores, window, kernel and output register.
`default_nettype none

// Streams RGB pixels in raster order and applies a signed Q4.12 3x3 kernel to each channel
// of every interior pixel; the one-pixel frame border passes through. The block takes one
// item per clock and gives one result per clock when the response side keeps up. An
// accepted item goes into a stage register that also holds the line-store read data, and
// its result reaches the output register when that stage item moves on, which waits while
// the output register is full and not taken. Output lags input by one row plus one pixel:
// the first image_width+1 pixels of a frame give no result, and drain items flush the
// owed outputs, the last marked frame_last. The request side stalls only while the stage
// holds a result and the output register is full and not taken. The line stores have no
// reset or clearing pass; the block is ready right after reset. Registers are written
// one per transfer and should only change while the block is idle.
module convolution_3x3_rgb_top #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   c3rgb_req_if.sink   req_ch,
   c3rgb_rsp_if.source rsp_ch,
   c3rgb_csr_if.sink   csr_ch
);

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int WID_W   = $clog2(MAX_WIDTH + 1);
   localparam int CMP_W   = (WID_W > c3rgb_pkg::IMG_WIDTH_W) ? WID_W : c3rgb_pkg::IMG_WIDTH_W;
   localparam int OWED_W  = $clog2(MAX_WIDTH + 2);
   localparam int ROW_W   = c3rgb_pkg::IMG_HEIGHT_W;
   localparam int CHAN_W  = c3rgb_pkg::CHAN_W;
   localparam int COEF_W  = c3rgb_pkg::COEF_W;
   localparam int PROD_W  = c3rgb_pkg::PROD_W;
   localparam int SUM_W   = c3rgb_pkg::SUM_W;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [c3rgb_pkg::COEF_ROW_W-1:0]   coef_ff [3];
   logic [c3rgb_pkg::IMG_WIDTH_W-1:0]  width_ff;
   logic [c3rgb_pkg::IMG_HEIGHT_W-1:0] height_ff;
   logic                               csr_fire;

   assign csr_ch.ready = 1'b1;
   assign csr_fire     = csr_ch.valid && csr_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[0] <= c3rgb_pkg::COEF_ROW0_RST;
         coef_ff[1] <= c3rgb_pkg::COEF_ROW1_RST;
         coef_ff[2] <= c3rgb_pkg::COEF_ROW2_RST;
         width_ff   <= c3rgb_pkg::IMG_WIDTH_RST;
         height_ff  <= c3rgb_pkg::IMG_HEIGHT_RST;
      end else if (csr_fire) begin
         unique case (c3rgb_pkg::csr_index_type'(csr_ch.index))
            c3rgb_pkg::CSR_COEF_ROW0:    coef_ff[0] <= csr_ch.data;
            c3rgb_pkg::CSR_COEF_ROW1:    coef_ff[1] <= csr_ch.data;
            c3rgb_pkg::CSR_COEF_ROW2:    coef_ff[2] <= csr_ch.data;
            c3rgb_pkg::CSR_IMAGE_WIDTH:
               width_ff <= csr_ch.data[c3rgb_pkg::IMG_WIDTH_W-1:0];
            c3rgb_pkg::CSR_IMAGE_HEIGHT:
               height_ff <= csr_ch.data[c3rgb_pkg::IMG_HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective geometry: width 0 acts as 1 and is capped at MAX_WIDTH, height 0 acts as 1
   logic [CMP_W-1:0] width_x;
   logic [WID_W-1:0] eff_w;
   logic [ROW_W-1:0] eff_h;

   assign width_x = CMP_W'(width_ff);

   always_comb begin
      priority if (width_ff == '0) begin
         eff_w = WID_W'(1);
      end else if (width_x > CMP_W'(MAX_WIDTH)) begin
         eff_w = WID_W'(MAX_WIDTH);
      end else begin
         eff_w = WID_W'(width_x);
      end
   end

   assign eff_h = (height_ff == '0) ? ROW_W'(1) : height_ff;

   // ------------------------------------------------------------------
   // Input side: column, owed count and drain column advance on transfer
   // ------------------------------------------------------------------
   logic [COL_W-1:0]  in_column_ff;
   logic [WID_W-1:0]  drain_col_ff;
   logic [OWED_W-1:0] owed_ff;

   logic             s1_valid_ff;
   logic             s2_adv;
   logic             s2_wr;
   logic             req_fire;
   logic             is_drain;
   logic             owed_full;
   logic             in_col_last;
   logic             drain_rd_ok;
   logic             s1_load;
   logic [COL_W-1:0] rd_addr;

   assign req_ch.ready = !s1_valid_ff || s2_adv;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign is_drain     = (req_ch.func == c3rgb_pkg::FUNC_DRAIN);
   assign owed_full    = owed_ff >= (OWED_W'(eff_w) + OWED_W'(1));
   assign in_col_last  = (WID_W'(in_column_ff) + WID_W'(1)) >= eff_w;
   assign drain_rd_ok  = drain_col_ff < eff_w;
   assign rd_addr      = is_drain ? drain_col_ff[COL_W-1:0] : in_column_ff;
   // A drain with nothing owed is taken and dropped
   assign s1_load      = req_fire && (!is_drain || (owed_ff != '0));

   always_ff @(posedge clock) begin
      if (reset) begin
         in_column_ff <= '0;
         drain_col_ff <= '0;
         owed_ff      <= '0;
      end else if (req_fire) begin
         if (!is_drain) begin
            in_column_ff <= in_col_last ? '0 : in_column_ff + COL_W'(1);
            drain_col_ff <= '0;
            if (!owed_full) begin
               owed_ff <= owed_ff + OWED_W'(1);
            end
         end else if (owed_ff != '0) begin
            if (drain_rd_ok) begin
               drain_col_ff <= drain_col_ff + WID_W'(1);
            end
            owed_ff <= owed_ff - OWED_W'(1);
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage register
   // ------------------------------------------------------------------
   logic                     s1_drain_ff;
   logic                     s1_emit_ff;
   logic                     s1_rd_ok_ff;
   c3rgb_pkg::pixel_type     s1_px_ff;
   logic [COL_W-1:0]         s1_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_load) begin
         s1_valid_ff <= 1'b1;
      end else if (s2_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_drain_ff <= is_drain;
         s1_emit_ff  <= is_drain ? 1'b1 : owed_full;
         s1_rd_ok_ff <= is_drain ? drain_rd_ok : 1'b1;
         s1_px_ff    <= {req_ch.in_red, req_ch.in_green, req_ch.in_blue};
         s1_addr_ff  <= rd_addr;
      end
   end

   // ------------------------------------------------------------------
   // Line stores, read on transfer, written when a pixel item leaves the stage
   // ------------------------------------------------------------------
   c3rgb_pkg::pixel_type line_above_mem [MAX_WIDTH];
   c3rgb_pkg::pixel_type line_two_mem   [MAX_WIDTH];
   c3rgb_pkg::pixel_type top_rd_ff;
   c3rgb_pkg::pixel_type mid_rd_ff;
   c3rgb_pkg::pixel_type byp_top_ff;
   c3rgb_pkg::pixel_type byp_mid_ff;
   logic                 byp_ff;
   c3rgb_pkg::pixel_type top_word;
   c3rgb_pkg::pixel_type mid_word;

   always_ff @(posedge clock) begin
      if (s2_wr) begin
         line_above_mem[s1_addr_ff] <= s1_px_ff;
         line_two_mem[s1_addr_ff]   <= mid_word;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         top_rd_ff <= line_two_mem[rd_addr];
         mid_rd_ff <= line_above_mem[rd_addr];
      end
   end

   // Forward the write landing at the same edge as the read of the same column
   always_ff @(posedge clock) begin
      if (s1_load) begin
         byp_ff     <= s2_wr && (s1_addr_ff == rd_addr);
         byp_top_ff <= mid_word;
         byp_mid_ff <= s1_px_ff;
      end
   end

   assign top_word = byp_ff ? byp_top_ff : top_rd_ff;
   assign mid_word = byp_ff ? byp_mid_ff : mid_rd_ff;

   // ------------------------------------------------------------------
   // Window shift
   // ------------------------------------------------------------------
   c3rgb_pkg::pixel_type win_ff [3][3];
   c3rgb_pkg::pixel_type win_in [3][3];
   c3rgb_pkg::pixel_type col_new [3];

   assign s2_adv = s1_valid_ff && (!s1_emit_ff || !rsp_ch.valid || rsp_ch.ready);
   assign s2_wr  = s2_adv && !s1_drain_ff;

   always_comb begin
      col_new[0] = s1_rd_ok_ff ? top_word : '0;
      col_new[1] = s1_rd_ok_ff ? mid_word : '0;
      col_new[2] = s1_drain_ff ? '0 : s1_px_ff;
      for (int r = 0; r < 3; r++) begin
         win_in[r][0] = win_ff[r][1];
         win_in[r][1] = win_ff[r][2];
         win_in[r][2] = col_new[r];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else if (s2_adv) begin
         win_ff <= win_in;
      end
   end

   // ------------------------------------------------------------------
   // Kernel: nine products per channel, row sums, clamp to 0..255
   // ------------------------------------------------------------------
   logic signed [PROD_W-1:0] prod    [3][3][3];
   logic signed [SUM_W-1:0]  row_sum [3][3];
   logic signed [SUM_W-1:0]  ch_sum  [3];
   logic signed [SUM_W-1:0]  ch_shr  [3];
   logic        [CHAN_W-1:0] filt    [3];

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               prod[ch][r][c] =
                  $signed({1'b0, win_in[r][c][CHAN_W*(2-ch) +: CHAN_W]}) *
                  $signed(coef_ff[r][COEF_W*c +: COEF_W]);
            end
            row_sum[ch][r] = SUM_W'(prod[ch][r][0]) + SUM_W'(prod[ch][r][1]) +
                             SUM_W'(prod[ch][r][2]);
         end
         ch_sum[ch] = row_sum[ch][0] + row_sum[ch][1] + row_sum[ch][2];
         ch_shr[ch] = ch_sum[ch] >>> c3rgb_pkg::COEF_FRAC_BITS;
         priority if (ch_sum[ch] < 0) begin
            filt[ch] = '0;
         end else if (ch_shr[ch] > SUM_W'(255)) begin
            filt[ch] = '1;
         end else begin
            filt[ch] = ch_shr[ch][CHAN_W-1:0];
         end
      end
   end

   // ------------------------------------------------------------------
   // Output position, border test and output register
   // ------------------------------------------------------------------
   logic [COL_W-1:0] out_column_ff;
   logic [ROW_W-1:0] out_row_ff;
   logic             out_col_last;
   logic             out_row_last;
   logic             interior;
   logic             out_load;
   logic [CHAN_W-1:0] out_red_ff;
   logic [CHAN_W-1:0] out_green_ff;
   logic [CHAN_W-1:0] out_blue_ff;
   logic              frame_last_ff;
   logic              out_valid_ff;

   assign out_col_last = (WID_W'(out_column_ff) + WID_W'(1)) >= eff_w;
   assign out_row_last = ((ROW_W + 1)'(out_row_ff) + (ROW_W + 1)'(1)) >= (ROW_W + 1)'(eff_h);
   assign interior     = (eff_w >= WID_W'(3)) && (eff_h >= ROW_W'(3)) &&
                         (out_row_ff != '0) &&
                         (((ROW_W + 1)'(out_row_ff) + (ROW_W + 1)'(2)) <= (ROW_W + 1)'(eff_h)) &&
                         (out_column_ff != '0) &&
                         (((WID_W + 1)'(out_column_ff) + (WID_W + 1)'(2)) <= (WID_W + 1)'(eff_w));
   assign out_load     = s2_adv && s1_emit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_column_ff <= '0;
         out_row_ff    <= '0;
      end else if (out_load) begin
         if (out_col_last) begin
            out_column_ff <= '0;
            out_row_ff    <= out_row_last ? '0 : out_row_ff + ROW_W'(1);
         end else begin
            out_column_ff <= out_column_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         if (interior) begin
            out_red_ff   <= filt[0];
            out_green_ff <= filt[1];
            out_blue_ff  <= filt[2];
         end else begin
            out_red_ff   <= win_in[1][1][2*CHAN_W +: CHAN_W];
            out_green_ff <= win_in[1][1][CHAN_W +: CHAN_W];
            out_blue_ff  <= win_in[1][1][0 +: CHAN_W];
         end
         frame_last_ff <= out_row_last && out_col_last;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.out_red    = out_red_ff;
   assign rsp_ch.out_green  = out_green_ff;
   assign rsp_ch.out_blue   = out_blue_ff;
   assign rsp_ch.frame_last = frame_last_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
`include "assert_macros.svh"

   `ASSERT_IMPLIES(a_owed_bound, clock, reset, 1'b1, owed_ff <= OWED_W'(MAX_WIDTH + 1), "owed count above one row plus one")
   `ASSERT_NEXT(a_owed_count, clock, reset, req_fire && !is_drain && !owed_full, owed_ff == $past(owed_ff) + OWED_W'(1), "owed count missed a pixel")
   `ASSERT_NEXT(a_empty_drain, clock, reset, req_fire && is_drain && (owed_ff == '0), !s1_valid_ff, "drain with nothing owed reached the stage")
   `ASSERT_IMPLIES(a_stall_cause, clock, reset, !req_ch.ready, s1_valid_ff && s1_emit_ff && out_valid_ff && !rsp_ch.ready, "request stalled without output backpressure")
   `ASSERT_IMPLIES(a_last_wraps, clock, reset, out_valid_ff && frame_last_ff, (out_column_ff == '0) && (out_row_ff == '0), "frame end did not wrap output position")

endmodule

`default_nettype wire
